### rtl/its_pkg.sv
// Shared constants, codes and controller/datapath interface types for the task scheduler.
package its_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int OP_W        = 3;
  localparam int IDX_W       = 8;
  localparam int TIME_W      = 32;
  localparam int STAT_W      = 2;
  localparam int OUT_SLOT_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_ADD     = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_TICK    = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_REFUSED = 2'd1,
    ST_DUE     = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture input beat
    logic exec_simple;  // clear_all / remove / enable / disable / unused
    logic exec_add;     // claim slot and load result
    logic tick_start;   // reset scan pointer and due mask
    logic scan_step;    // evaluate one slot
    logic emit;         // load lowest due slot into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_last;
    logic            due_any;
    logic            emit_last;
    logic            out_room;
  } dp_stat_t;

  // slot number as reported on task_slot (masked / extended to 3 bits)
  function automatic logic [OUT_SLOT_W-1:0] to_task_slot(input logic [SLOT_W-1:0] s);
    return OUT_SLOT_W'(s);
  endfunction

endpackage

### rtl/its_ctrl.sv
// Sequencing state machine for the task scheduler.
module its_ctrl
  import its_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_ADD: begin
            if (stat.out_room) begin
              cmd.exec_add = 1'b1;
              state_next   = S_IDLE;
            end
          end
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = S_SCAN;
          end
          default: begin
            cmd.exec_simple = 1'b1;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.due_any) begin
          state_next = S_IDLE;
        end else if (stat.out_room) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/its_datapath.sv
// Slot table, tick scan unit, due mask and output register of the task scheduler.
module its_datapath
  import its_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic [OP_W-1:0]       opcode,
  input  logic [IDX_W-1:0]      slot_index,
  input  logic [TIME_W-1:0]     period_ms,
  input  logic [TIME_W-1:0]     now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [OUT_SLOT_W-1:0] out_slot,
  output logic                  out_last
);

  // captured beat
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TIME_W-1:0] interval_q;
  logic [TIME_W-1:0] now_q;

  // slot table
  logic [TASK_SLOTS-1:0] used;
  logic [TASK_SLOTS-1:0] enabled;
  logic [TIME_W-1:0]     interval_tbl [TASK_SLOTS];
  logic [TIME_W-1:0]     last_run_tbl [TASK_SLOTS];
  logic                  ready;

  // tick scan
  logic [SLOT_W-1:0]     scan_idx;
  logic [TASK_SLOTS-1:0] due;
  logic [CNT_W-1:0]      due_cnt;

  logic                  in_range;
  logic [SLOT_W-1:0]     sel_idx;
  logic [SLOT_W-1:0]     free_slot;
  logic                  any_free;
  logic                  add_ok;
  logic [TIME_W-1:0]     elapsed;
  logic                  hit;
  logic [TASK_SLOTS-1:0] due_low;
  logic [SLOT_W-1:0]     due_slot;
  logic                  out_room;

  assign in_range = (idx_q < IDX_W'(TASK_SLOTS));
  assign sel_idx  = idx_q[SLOT_W-1:0];
  assign any_free = ~&used;
  assign add_ok   = ready && any_free;
  assign out_room = !out_valid || !out_stall;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // one slot per scan cycle: wrapping elapsed time against interval
  assign elapsed = now_q - last_run_tbl[scan_idx];
  assign hit     = used[scan_idx] && enabled[scan_idx] &&
                   (elapsed >= interval_tbl[scan_idx]) &&
                   (due_cnt < CNT_W'(MAX_RESULTS));

  // lowest pending due slot
  assign due_low = due & (~due + TASK_SLOTS'(1));
  always_comb begin
    due_slot = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (due[i]) begin
        due_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.scan_last = (scan_idx == SLOT_W'(TASK_SLOTS - 1));
    stat.due_any   = |due;
    stat.emit_last = ((due & ~due_low) == '0);
    stat.out_room  = out_room;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      enabled   <= '0;
      ready     <= 1'b0;
      due       <= '0;
      due_cnt   <= '0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec_simple) begin
        unique case (op_q)
          OP_CLEAR: begin
            used    <= '0;
            enabled <= '0;
            ready   <= 1'b1;
          end
          OP_REMOVE: begin
            if (in_range) begin
              used[sel_idx]    <= 1'b0;
              enabled[sel_idx] <= 1'b0;
            end
          end
          OP_ENABLE: begin
            if (in_range) begin
              enabled[sel_idx] <= 1'b1;
            end
          end
          OP_DISABLE: begin
            if (in_range) begin
              enabled[sel_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.exec_add && add_ok) begin
        used[free_slot]    <= 1'b1;
        enabled[free_slot] <= 1'b1;
      end
      if (cmd.tick_start) begin
        due      <= '0;
        due_cnt  <= '0;
        scan_idx <= '0;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + SLOT_W'(1);
        if (hit) begin
          due[scan_idx] <= 1'b1;
          due_cnt       <= due_cnt + CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        due <= due & ~due_low;
      end
      if (cmd.exec_add || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= opcode;
      idx_q      <= slot_index;
      interval_q <= period_ms;
      now_q      <= now_ms;
    end
    if (cmd.exec_add && add_ok) begin
      interval_tbl[free_slot] <= interval_q;
      last_run_tbl[free_slot] <= now_q;
    end
    if (cmd.scan_step && hit) begin
      last_run_tbl[scan_idx] <= now_q;
    end
    if (cmd.exec_add) begin
      out_status <= add_ok ? ST_ADDED : ST_REFUSED;
      out_slot   <= add_ok ? to_task_slot(free_slot) : '0;
      out_last   <= 1'b1;
    end else if (cmd.emit) begin
      out_status <= ST_DUE;
      out_slot   <= to_task_slot(due_slot);
      out_last   <= stat.emit_last;
    end
  end

  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_start |=> (due == '0) && (due_cnt == '0) && (scan_idx == '0))
    else $error("tick did not clear scan state");

  a_add_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec_add |=> out_valid && out_last && (out_status != ST_DUE))
    else $error("add produced no final add result");

  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (due != '0)) |=> out_valid && (out_status == ST_DUE))
    else $error("emit produced no due result");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.exec_add) |-> out_room)
    else $error("output register overwritten while stalled");

endmodule

### rtl/interval_task_scheduler.sv
// Interval task scheduler top level: controller plus slot table datapath.
// One beat in flight. Non-tick beats are accepted, then executed in decode; the add result is
// registered at the execute edge, and an add holds there while the last result is stalled.
// Tick: decode, then a scan of all TASK_SLOTS slots (one slot per cycle on the shared 32-bit
// elapsed compare), then one due beat per cycle as the sink allows.
// Reset (rst, synchronous): controller idle; slot marks, ready, due mask, output valid cleared.
module interval_task_scheduler
  import its_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       opcode,
  input  logic [IDX_W-1:0]      slot_index,
  input  logic [TIME_W-1:0]     period_ms,
  input  logic [TIME_W-1:0]     now_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     status,
  output logic [OUT_SLOT_W-1:0] task_slot,
  output logic                  last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // controller: sequences decode, scan and emission; stalls input while busy
  its_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: slot table, scan pointer, due mask, output register
  its_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .slot_index  (slot_index),
    .period_ms   (period_ms),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (status),
    .out_slot    (task_slot),
    .out_last    (last)
  );

endmodule

### sim/interval_task_scheduler_test.sv
// Self-checking testbench for the interval task scheduler: directed and random op beats.
`timescale 1ns / 1ps

module interval_task_scheduler_test;
  import its_pkg::*;

  // opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_OPS = 133;
  // cycles with no beat on either channel before the run is abandoned; it must outlast
  // a tick scan, a result held under stall and a sender gap
  localparam int IDLE_LIMIT = 2000;
  // settle time after the last expected result, sized from the tick scan length
  localparam int TAIL_CYCLES = 4 * (2 + TASK_SLOTS);
  localparam int MAX_REPORTS = 10;

  // one operation beat as queued for the sender
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] now;
    bit                drain;   // hold this beat until every reply is back
  } sched_op_t;

  // one reply beat
  typedef struct packed {
    logic [STAT_W-1:0]     st;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  fin;
  } sched_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       opcode = OP_CLEAR;
  logic [IDX_W-1:0]      slot_index = '0;
  logic [TIME_W-1:0]     period_ms = '0;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STAT_W-1:0]     status;
  logic [OUT_SLOT_W-1:0] task_slot;
  logic                  last;

  interval_task_scheduler u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .slot_index (slot_index),
    .period_ms  (period_ms),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .task_slot  (task_slot),
    .last       (last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: slot table, ready flag, and replies still owed by the DUT
  // ---------------------------------------------------------------------------
  bit                tbl_used   [TASK_SLOTS];
  bit                tbl_en     [TASK_SLOTS];
  logic [TIME_W-1:0] tbl_period [TASK_SLOTS];
  logic [TIME_W-1:0] tbl_stamp  [TASK_SLOTS];
  bit                tbl_ready;

  sched_op_t    op_backlog[$];    // beats not yet accepted by the DUT
  sched_reply_t owed_replies[$];  // replies predicted, not yet seen

  int ops_sent    = 0;   // beats presented by the sender
  int ops_taken   = 0;   // beats accepted on the input channel
  int replies_got = 0;
  int due_got     = 0;
  int refused_got = 0;
  int mismatches  = 0;
  int idle_cycles = 0;

  initial begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tbl_used[i]   = 1'b0;
      tbl_en[i]     = 1'b0;
      tbl_period[i] = '0;
      tbl_stamp[i]  = '0;
    end
    tbl_ready = 1'b0;
  end

  task automatic owe_reply(input logic [STAT_W-1:0] st, input int slot, input bit fin);
    sched_reply_t r;
    r.st   = st;
    r.slot = OUT_SLOT_W'(slot);
    r.fin  = fin;
    owed_replies.push_back(r);
  endtask

  // Apply one accepted op to the shadow table and queue the replies it causes.
  task automatic apply_sched_op(input sched_op_t b);
    int free_slot;
    int due_slots[$];
    logic [TIME_W-1:0] elapsed;
    free_slot = -1;
    case (b.op)
      OP_CLEAR: begin
        // intervals and stamps survive a clear
        for (int i = 0; i < TASK_SLOTS; i++) begin
          tbl_used[i] = 1'b0;
          tbl_en[i]   = 1'b0;
        end
        tbl_ready = 1'b1;
      end
      OP_ADD: begin
        if (tbl_ready) begin
          for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!tbl_used[i]) free_slot = i;
          end
        end
        if (free_slot >= 0) begin
          tbl_used[free_slot]   = 1'b1;
          tbl_en[free_slot]     = 1'b1;
          tbl_period[free_slot] = b.interval;
          tbl_stamp[free_slot]  = b.now;
          owe_reply(ST_ADDED, free_slot, 1'b1);
        end else begin
          // uninitialised or full: slot reported as zero
          owe_reply(ST_REFUSED, 0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (b.idx < TASK_SLOTS) begin
          tbl_used[b.idx] = 1'b0;
          tbl_en[b.idx]   = 1'b0;
        end
      end
      OP_ENABLE: begin
        if (b.idx < TASK_SLOTS) tbl_en[b.idx] = 1'b1;
      end
      OP_DISABLE: begin
        if (b.idx < TASK_SLOTS) tbl_en[b.idx] = 1'b0;
      end
      OP_TICK: begin
        // slot order; anything past MAX_RESULTS stays due for the next tick
        for (int i = 0; i < TASK_SLOTS; i++) begin
          elapsed = b.now - tbl_stamp[i];
          if (due_slots.size() < MAX_RESULTS && tbl_used[i] && tbl_en[i] &&
              elapsed >= tbl_period[i]) begin
            due_slots.push_back(i);
            tbl_stamp[i] = b.now;
          end
        end
        foreach (due_slots[j]) owe_reply(ST_DUE, due_slots[j], j == due_slots.size() - 1);
      end
      default: ;  // spare opcodes do nothing
    endcase
  endtask

  task automatic note_mismatch(input string what, input sched_reply_t want,
                               input sched_reply_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch: %s  exp status=%0d slot=%0d last=%0d",
               $realtime, what, want.st, want.slot, want.fin,
               "  got status=%0d slot=%0d last=%0d", got.st, got.slot, got.fin);
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: check reply beats, then predict from the accepted op beat.
  // A reply can never belong to the op taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sched_reply_t got;
    sched_reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.st   = status;
        got.slot = task_slot;
        got.fin  = last;
        replies_got++;
        if (status == ST_DUE) due_got++;
        if (status == ST_REFUSED) refused_got++;
        if (owed_replies.size() == 0) begin
          want = '0;
          note_mismatch("reply beat with nothing owed", want, got);
        end else begin
          want = owed_replies.pop_front();
          if (got !== want) note_mismatch("reply field differs", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        apply_sched_op(op_backlog[0]);
        void'(op_backlog.pop_front());
        ops_taken++;
      end
    end
  end

  // watchdog: any beat on either channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d ops and %0d replies outstanding",
               IDLE_LIMIT, op_backlog.size(), owed_replies.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; payload held until taken.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && ops_taken != ops_sent) begin
      // still waiting on the handshake: hold everything
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (op_backlog.size() != 0 &&
                 (!op_backlog[0].drain || owed_replies.size() == 0)) begin
      in_valid    <= 1'b1;
      opcode      <= op_backlog[0].op;
      slot_index  <= op_backlog[0].idx;
      period_ms   <= op_backlog[0].interval;
      now_ms      <= op_backlog[0].now;
      ops_sent    <= ops_sent + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        // about a third of bursts run straight into the next one
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall mode changes periodically - free running, random independent
  // stalls, or long held stalls.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_timer = 0;
  int hold_left  = 0;

  always @(negedge clk) begin
    if (mode_timer == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_timer <= 63;
    end else begin
      mode_timer <= mode_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left <= hold_left - 1;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
          hold_left <= $urandom_range(1, 20);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [TIME_W-1:0] interval, input logic [TIME_W-1:0] now,
                          input bit drain);
    sched_op_t b;
    b.op       = op;
    b.idx      = idx;
    b.interval = interval;
    b.now      = now;
    b.drain    = drain;
    op_backlog.push_back(b);
  endtask

  initial begin
    logic [TIME_W-1:0] clock_ms;
    int pick;
    int total_ops;

    // --- directed part ---
    // add before any clear_all must be refused; tick on an empty table is silent
    queue_op(OP_ADD, 8'd0, 32'd5, 32'd0, 0);
    queue_op(OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF, 0);
    // remove/enable/disable work before init; index 255 is out of range
    queue_op(OP_ENABLE, 8'd3, 32'd0, 32'd0, 0);
    queue_op(OP_DISABLE, 8'd3, 32'd0, 32'd0, 0);
    queue_op(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_op(OP_CLEAR, 8'd0, 32'd0, 32'd0, 0);
    // fill all slots, zero and all-ones intervals among them
    queue_op(OP_ADD, 8'd0, 32'd0, 32'd0, 0);
    queue_op(OP_ADD, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_op(OP_ADD, 8'd0, 32'd10, 32'hFFFF_FFF0, 0);
    queue_op(OP_ADD, 8'd0, 32'd20, 32'hFFFF_FFF0, 0);
    queue_op(OP_ADD, 8'd0, 32'd1, 32'hFFFF_FFF0, 0);
    queue_op(OP_ADD, 8'd0, 32'h8000_0000, 32'd0, 0);
    queue_op(OP_ADD, 8'd0, 32'd3, 32'hFFFF_FFF0, 0);
    queue_op(OP_ADD, 8'd0, 32'd100, 32'hFFFF_FFF0, 0);
    queue_op(OP_ADD, 8'd0, 32'd7, 32'd0, 0);               // table full
    queue_op(OP_TICK, 8'd0, 32'd0, 32'd5, 0);              // elapsed wraps past 2^32
    queue_op(OP_DISABLE, 8'd1, 32'd0, 32'd0, 0);
    queue_op(OP_ENABLE, 8'd200, 32'd0, 32'd0, 0);          // out of range
    queue_op(OP_REMOVE, 8'd8, 32'd0, 32'd0, 0);            // first index past the table
    queue_op(OP_REMOVE, 8'd2, 32'd0, 32'd0, 0);
    queue_op(OP_ENABLE, 8'd2, 32'd0, 32'd0, 0);            // enable on a free slot
    queue_op(OP_ADD, 8'd0, 32'd4, 32'd6, 0);               // reclaims slot 2
    queue_op(OP_SPARE_6, 8'hA5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 0);
    queue_op(OP_SPARE_7, 8'h5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0);
    queue_op(OP_TICK, 8'd0, 32'd0, 32'h8000_0010, 0);      // nearly every slot due
    queue_op(OP_ENABLE, 8'd1, 32'd0, 32'd0, 0);
    queue_op(OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFE, 1);      // all-ones interval just reached

    // --- random part: a running millisecond clock that wraps early on ---
    clock_ms = 32'hFFFF_FF80;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_op(OP_CLEAR, 8'($urandom), $urandom, $urandom, 0);
      end else if (pick < 28) begin
        queue_op(OP_ADD, 8'($urandom),
                 ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60),
                 clock_ms, 0);
      end else if (pick < 54) begin
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 25);
        queue_op(OP_TICK, 8'($urandom), $urandom, clock_ms, 0);
      end else if (pick < 97) begin
        // remove / enable / disable, mostly near the table
        queue_op((pick < 70) ? OP_REMOVE : (pick < 84) ? OP_ENABLE : OP_DISABLE,
                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9)),
                 $urandom, $urandom, 0);
      end else begin
        queue_op((pick < 99) ? OP_SPARE_6 : OP_SPARE_7, 8'($urandom), $urandom, $urandom, 0);
      end
      // every so often the sender waits for the block to drain completely
      if (n % 40 == 39) op_backlog[op_backlog.size() - 1].drain = 1;
    end
    total_ops = op_backlog.size();

    // reset asserted from time zero, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (ops_taken < total_ops || owed_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (owed_replies.size() != 0) begin
      mismatches += owed_replies.size();
      $display("%0d predicted replies never arrived", owed_replies.size());
    end

    $display("Covered %0d op beats (%0d directed) and %0d reply beats: %0d due, %0d refused.",
             ops_taken, total_ops - RANDOM_OPS, replies_got, due_got, refused_got);
    $display("Mismatching or missing reply beats: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/its_pkg.sv
rtl/its_ctrl.sv
rtl/its_datapath.sv
rtl/interval_task_scheduler.sv
sim/interval_task_scheduler_test.sv
